FILE: hdl/dlct_pkg.sv
// Shared constants, codes and controller/datapath interface structs for the
// line counter tachometer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dlct_pkg;

   localparam int TIME_W        = 32;
   localparam int LINE_W        = 32;
   localparam int ENC_GAP_W     = 16;
   localparam int SYNC_GAP_W    = 24;
   localparam int RPM_W         = 24;
   localparam int RPM_FRAC_BITS = 8;

   // 60e6 fits in 26 bits; the scaled numerator grows by the fraction bits
   localparam int NUM_W = 26 + RPM_FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(64'd60000000 << RPM_FRAC_BITS);
   localparam logic [RPM_W-1:0] RPM_MAX       = {RPM_W{1'b1}};

   localparam logic [ENC_GAP_W-1:0]  ENC_GAP_RESET  = ENC_GAP_W'(400);
   localparam logic [SYNC_GAP_W-1:0] SYNC_GAP_RESET = SYNC_GAP_W'(100000);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_ENC_GAP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_GAP = 1'b1;

   // event kinds on the request tuser
   localparam logic OP_ENCODER = 1'b0;
   localparam logic OP_SYNC    = 1'b1;

   typedef struct packed {
      logic load;      // capture request beat
      logic eval;      // judge debounce, prime divider
      logic div_step;  // one quotient bit
      logic emit;      // load response register, commit state
   } dlct_cmd_type;

   typedef struct packed {
      logic item_sync;
      logic pass_now;
      logic div_last;
      logic out_free;
   } dlct_status_type;

endpackage
`default_nettype wire

FILE: hdl/dlct_datapath.sv
// Datapath: item capture, debounce compare, tachometer state, restoring
// divider for rpm and the response register. Depends on dlct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlct_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dlct_pkg::dlct_cmd_type            cmd,
   output dlct_pkg::dlct_status_type              status,
   input  wire logic                              csr_we,
   input  wire logic [dlct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dlct_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [dlct_pkg::TIME_W-1:0]       req_tdata,
   input  wire logic [0:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [55:0]                            rsp_tdata,
   output logic [1:0]                             rsp_tuser
);

   logic [dlct_pkg::ENC_GAP_W-1:0]  enc_gap_ff,  enc_gap_in;
   logic [dlct_pkg::SYNC_GAP_W-1:0] sync_gap_ff, sync_gap_in;

   logic                          item_sync_ff, item_sync_in;
   logic [dlct_pkg::TIME_W-1:0]   item_time_ff, item_time_in;
   logic                          pass_ff, pass_in;

   logic [dlct_pkg::TIME_W-1:0]   last_enc_ff,  last_enc_in;
   logic [dlct_pkg::TIME_W-1:0]   last_sync_ff, last_sync_in;
   logic [dlct_pkg::LINE_W-1:0]   line_cnt_ff,  line_cnt_in;
   logic [dlct_pkg::RPM_W-1:0]    rpm_ff,       rpm_in;

   logic [dlct_pkg::TIME_W-1:0]   div_rem_ff, div_rem_in;
   logic [dlct_pkg::TIME_W-1:0]   div_den_ff, div_den_in;
   logic [dlct_pkg::NUM_W-1:0]    div_num_ff, div_num_in;
   logic [dlct_pkg::NUM_W-1:0]    div_quo_ff, div_quo_in;
   logic [dlct_pkg::CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_line_ff,  rsp_line_in;
   logic                          rsp_sync_ff,  rsp_sync_in;
   logic [dlct_pkg::LINE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [dlct_pkg::RPM_W-1:0]    rsp_rpm_ff,   rsp_rpm_in;

   logic [dlct_pkg::TIME_W-1:0]   elapsed;
   logic [dlct_pkg::TIME_W-1:0]   min_gap;
   logic [dlct_pkg::TIME_W:0]     trial;
   logic [dlct_pkg::TIME_W+1:0]   diff;
   logic                          line_ok;
   logic                          sync_ok;
   logic [dlct_pkg::RPM_W-1:0]    rpm_sat;

   // debounce: wrapped elapsed time against the gap of this event kind
   always_comb begin
      if (item_sync_ff == dlct_pkg::OP_SYNC) begin
         elapsed = item_time_ff - last_sync_ff;
         min_gap = dlct_pkg::TIME_W'(sync_gap_ff);
      end else begin
         elapsed = item_time_ff - last_enc_ff;
         min_gap = dlct_pkg::TIME_W'(enc_gap_ff);
      end
   end

   // restoring divide step; zero divisor gives all ones and saturates
   assign trial = {div_rem_ff, div_num_ff[dlct_pkg::NUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_den_ff};

   assign rpm_sat = (div_quo_ff[dlct_pkg::NUM_W-1:dlct_pkg::RPM_W] != '0)
                    ? dlct_pkg::RPM_MAX : div_quo_ff[dlct_pkg::RPM_W-1:0];

   assign line_ok = pass_ff && (item_sync_ff == dlct_pkg::OP_ENCODER);
   assign sync_ok = pass_ff && (item_sync_ff == dlct_pkg::OP_SYNC);

   assign status.item_sync = (item_sync_ff == dlct_pkg::OP_SYNC);
   assign status.pass_now  = (elapsed >= min_gap);
   assign status.div_last  = (div_cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      enc_gap_in   = enc_gap_ff;
      sync_gap_in  = sync_gap_ff;
      item_sync_in = item_sync_ff;
      item_time_in = item_time_ff;
      pass_in      = pass_ff;
      last_enc_in  = last_enc_ff;
      last_sync_in = last_sync_ff;
      line_cnt_in  = line_cnt_ff;
      rpm_in       = rpm_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_num_in   = div_num_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_line_in  = rsp_line_ff;
      rsp_sync_in  = rsp_sync_ff;
      rsp_index_in = rsp_index_ff;
      rsp_rpm_in   = rsp_rpm_ff;

      if (csr_we) begin
         case (csr_index)
            dlct_pkg::REG_ENC_GAP:  enc_gap_in  = csr_wdata[dlct_pkg::ENC_GAP_W-1:0];
            dlct_pkg::REG_SYNC_GAP: sync_gap_in = csr_wdata[dlct_pkg::SYNC_GAP_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         item_sync_in = req_tuser[0];
         item_time_in = req_tdata;
      end

      if (cmd.eval) begin
         pass_in    = status.pass_now;
         div_rem_in = '0;
         div_den_in = elapsed;
         div_num_in = dlct_pkg::RPM_NUMERATOR;
         div_quo_in = '0;
         div_cnt_in = dlct_pkg::CNT_W'(dlct_pkg::NUM_W - 1);
      end

      if (cmd.div_step) begin
         div_num_in = {div_num_ff[dlct_pkg::NUM_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff - 1'b1;
         if (!diff[dlct_pkg::TIME_W+1]) begin
            div_rem_in = diff[dlct_pkg::TIME_W-1:0];
            div_quo_in = {div_quo_ff[dlct_pkg::NUM_W-2:0], 1'b1};
         end else begin
            div_rem_in = trial[dlct_pkg::TIME_W-1:0];
            div_quo_in = {div_quo_ff[dlct_pkg::NUM_W-2:0], 1'b0};
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_line_in  = line_ok;
         rsp_sync_in  = sync_ok;
         rsp_index_in = line_ok ? line_cnt_ff : '0;
         rsp_rpm_in   = sync_ok ? rpm_sat : rpm_ff;
         if (line_ok) begin
            last_enc_in = item_time_ff;
            line_cnt_in = line_cnt_ff + 1'b1;
         end
         if (sync_ok) begin
            last_sync_in = item_time_ff;
            line_cnt_in  = '0;
            rpm_in       = rpm_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_gap_ff   <= dlct_pkg::ENC_GAP_RESET;
         sync_gap_ff  <= dlct_pkg::SYNC_GAP_RESET;
         last_enc_ff  <= '0;
         last_sync_ff <= '0;
         line_cnt_ff  <= '0;
         rpm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enc_gap_ff   <= enc_gap_in;
         sync_gap_ff  <= sync_gap_in;
         last_enc_ff  <= last_enc_in;
         last_sync_ff <= last_sync_in;
         line_cnt_ff  <= line_cnt_in;
         rpm_ff       <= rpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_sync_ff <= item_sync_in;
      item_time_ff <= item_time_in;
      pass_ff      <= pass_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_num_ff   <= div_num_in;
      div_quo_ff   <= div_quo_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_sync_ff  <= rsp_sync_in;
      rsp_index_ff <= rsp_index_in;
      rsp_rpm_ff   <= rsp_rpm_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_rpm_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_sync_ff, rsp_line_ff};

endmodule
`default_nettype wire

FILE: hdl/dlct_ctrl.sv
// Controller FSM: sequences capture, debounce, divide and response load.
// Depends on dlct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlct_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   output dlct_pkg::dlct_cmd_type            cmd,
   input  wire dlct_pkg::dlct_status_type    status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.eval     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            // only an accepted sync needs the divider
            if (status.item_sync && status.pass_now) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/debounced_line_counter_tachometer.sv
// Request capture, evaluation, then response load for an encoder edge or a debounced
// edge; an accepted sync also steps the restoring divider (one rpm quotient bit
// per cycle) before the response load. One item in flight; next request beat is
// taken the cycle after the response register loads, while that beat waits.
// Reset (synchronous): gaps to 400 us / 100000 us, times, line count, rpm zero.
`timescale 1ns / 1ps
`default_nettype none
module debounced_line_counter_tachometer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [31:0]                       req_tdata,  // [31:0] timestamp_us
   input  wire logic [0:0]                        req_tuser,  // [0] operation
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [55:0]                            rsp_tdata,  // [31:0] line_index, [55:32] rpm_q8
   output logic [1:0]                             rsp_tuser,  // [0] line_valid, [1] sync_valid
   input  wire logic                              csr_we,
   input  wire logic [dlct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dlct_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dlct_pkg::dlct_cmd_type    cmd;
   dlct_pkg::dlct_status_type status;

   dlct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dlct_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
